/* src/rph_pkg.sv */
// Package for the RGB pixel histogram: payload structs, field widths,
// register indexes and default sizes. No dependencies.
package rph_pkg;

    localparam int SAMPLE_BITS       = 16;
    localparam int GAIN_BITS         = 32;
    localparam int INDEX_FIELD_BITS  = 16;
    localparam int COUNT_FIELD_BITS  = 32;
    localparam int PRODUCT_BITS      = SAMPLE_BITS + GAIN_BITS;
    localparam int BIN_SHIFT         = 24;
    localparam int SCALED_BITS       = PRODUCT_BITS - BIN_SHIFT;
    localparam int CHANNELS          = 3;

    localparam int DEFAULT_BIN_BITS   = 16;
    localparam int DEFAULT_COUNT_BITS = 32;

    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 32;

    localparam logic [CFG_INDEX_BITS-1:0] REG_GAIN     = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_IS_COLOR = 1'b1;

    localparam logic [GAIN_BITS-1:0] GAIN_RESET = 32'h0100_0000;

    localparam logic ACT_ACCUMULATE = 1'b0;
    localparam logic ACT_READ       = 1'b1;

    typedef struct packed {
        logic                        action;
        logic [SAMPLE_BITS-1:0]      red_sample;
        logic [SAMPLE_BITS-1:0]      green_sample;
        logic [SAMPLE_BITS-1:0]      blue_sample;
        logic [INDEX_FIELD_BITS-1:0] bin_index;
    } pixel_t;

    typedef struct packed {
        logic [COUNT_FIELD_BITS-1:0] red_count;
        logic [COUNT_FIELD_BITS-1:0] green_count;
        logic [COUNT_FIELD_BITS-1:0] blue_count;
    } result_t;

endpackage

/* src/rph_scale.sv */
// Sample-to-bin scaler: registered 16 x 32 product, then shift and clamp.
// Depends on rph_pkg.
module rph_scale import rph_pkg::*; #(
    parameter int BIN_BITS = DEFAULT_BIN_BITS
) (
    input  logic                   clk,
    input  logic                   load,
    input  logic [SAMPLE_BITS-1:0] sample,
    input  logic [GAIN_BITS-1:0]   gain,
    output logic [BIN_BITS-1:0]    bin
);

    localparam logic [SCALED_BITS-1:0] BIN_MAX = SCALED_BITS'((1 << BIN_BITS) - 1);

    logic [PRODUCT_BITS-1:0] product_reg;
    logic [SCALED_BITS-1:0]  scaled;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            product_reg <= PRODUCT_BITS'(sample) * PRODUCT_BITS'(gain);
        end
    end

    assign scaled = product_reg[PRODUCT_BITS-1:BIN_SHIFT];
    assign bin    = (scaled > BIN_MAX) ? BIN_MAX[BIN_BITS-1:0] : scaled[BIN_BITS-1:0];

endmodule

/* src/rph_bank.sv */
// One channel's bin store: synchronous memory with one write port and one
// read port, read data registered. Depends on rph_pkg.
module rph_bank import rph_pkg::*; #(
    parameter int ADDR_BITS = DEFAULT_BIN_BITS,
    parameter int DATA_BITS = DEFAULT_COUNT_BITS
) (
    input  logic                 clk,
    input  logic                 wr_en,
    input  logic [ADDR_BITS-1:0] wr_addr,
    input  logic [DATA_BITS-1:0] wr_data,
    input  logic                 rd_en,
    input  logic [ADDR_BITS-1:0] rd_addr,
    output logic [DATA_BITS-1:0] rd_data
);

    logic [DATA_BITS-1:0] mem_array [2**ADDR_BITS];
    logic [DATA_BITS-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_array[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* src/rgb_pixel_histogram.sv */
// Steps: an accumulate transaction passes accept, scale and read, update and write; a read
// transaction reads its bin on acceptance, then registers its result in the reply state, which
// waits while the result slot is full. Bins are updated by read-modify-write through the
// single read and write ports; pixel_ready is high only in the idle state, between transactions.
// Reset: asynchronous, active low; a clearing pass over all 2**BIN_BITS bins zeroes them,
// during which no pixel transaction is accepted. Configuration writes are taken at any time.
module rgb_pixel_histogram import rph_pkg::*; #(
    parameter int BIN_BITS   = DEFAULT_BIN_BITS,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      pixel_valid,
    output logic                      pixel_ready,
    input  pixel_t                    pixel,
    output logic                      result_valid,
    input  logic                      result_ready,
    output result_t                   result
);

    typedef enum logic [4:0] {
        S_CLEAR  = 5'b00001,
        S_IDLE   = 5'b00010,
        S_SCALE  = 5'b00100,
        S_UPDATE = 5'b01000,
        S_REPLY  = 5'b10000
    } state_t;

    localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
    localparam logic [BIN_BITS-1:0]   LAST_BIN  = '1;

    state_t                state_reg, state_next;
    logic [BIN_BITS-1:0]   clr_addr_reg, clr_addr_next;
    logic [GAIN_BITS-1:0]  gain_reg;
    logic                  is_color_reg;
    logic                  result_valid_reg, result_valid_next;
    result_t               result_reg, result_next;

    logic                  pixel_accept;
    logic                  scale_load;
    logic                  clearing;
    logic                  mem_wr_en;
    logic                  mem_rd_en;
    logic                  slot_free;

    logic [SAMPLE_BITS-1:0] sample   [CHANNELS];
    logic [BIN_BITS-1:0]    bin_scaled [CHANNELS];
    logic [BIN_BITS-1:0]    bin_reg  [CHANNELS];
    logic [BIN_BITS-1:0]    rd_addr  [CHANNELS];
    logic [BIN_BITS-1:0]    wr_addr  [CHANNELS];
    logic [COUNT_BITS-1:0]  wr_data  [CHANNELS];
    logic [COUNT_BITS-1:0]  count_rd [CHANNELS];

    assign pixel_ready  = (state_reg == S_IDLE);
    assign pixel_accept = pixel_valid && pixel_ready;
    assign scale_load   = pixel_accept && (pixel.action == ACT_ACCUMULATE);
    assign clearing     = (state_reg == S_CLEAR);
    assign mem_wr_en    = clearing || (state_reg == S_UPDATE);
    assign mem_rd_en    = (pixel_accept && (pixel.action == ACT_READ)) || (state_reg == S_SCALE);
    assign slot_free    = !result_valid_reg || result_ready;

    assign sample[0] = pixel.red_sample;
    assign sample[1] = pixel.green_sample;
    assign sample[2] = pixel.blue_sample;

    for (genvar ch = 0; ch < CHANNELS; ch++)
    begin : g_channel
        rph_scale #(
            .BIN_BITS (BIN_BITS)
        ) u_scale (
            .clk    (clk),
            .load   (scale_load),
            .sample (sample[ch]),
            .gain   (gain_reg),
            .bin    (bin_scaled[ch])
        );

        always_ff @(posedge clk)
        begin
            if (state_reg == S_SCALE)
            begin
                bin_reg[ch] <= bin_scaled[ch];
            end
        end

        assign rd_addr[ch] = (state_reg == S_SCALE) ? bin_scaled[ch]
                                                    : pixel.bin_index[BIN_BITS-1:0];
        assign wr_addr[ch] = clearing ? clr_addr_reg : bin_reg[ch];
        assign wr_data[ch] = clearing ? '0
                           : (count_rd[ch] == COUNT_MAX) ? count_rd[ch]
                           : count_rd[ch] + COUNT_BITS'(1);

        rph_bank #(
            .ADDR_BITS (BIN_BITS),
            .DATA_BITS (COUNT_BITS)
        ) u_bank (
            .clk     (clk),
            .wr_en   (mem_wr_en),
            .wr_addr (wr_addr[ch]),
            .wr_data (wr_data[ch]),
            .rd_en   (mem_rd_en),
            .rd_addr (rd_addr[ch]),
            .rd_data (count_rd[ch])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_reg     <= GAIN_RESET;
            is_color_reg <= 1'b1;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                REG_GAIN:     gain_reg     <= cfg_wdata[GAIN_BITS-1:0];
                REG_IS_COLOR: is_color_reg <= cfg_wdata[0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        state_next        = state_reg;
        clr_addr_next     = clr_addr_reg;
        result_valid_next = result_valid_reg && !result_ready;
        result_next       = result_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                clr_addr_next = clr_addr_reg + BIN_BITS'(1);
                if (clr_addr_reg == LAST_BIN)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (pixel_accept)
                begin
                    state_next = (pixel.action == ACT_READ) ? S_REPLY : S_SCALE;
                end
            end
            S_SCALE:
            begin
                state_next = S_UPDATE;
            end
            S_UPDATE:
            begin
                state_next = S_IDLE;
            end
            S_REPLY:
            begin
                if (slot_free)
                begin
                    result_valid_next     = 1'b1;
                    result_next.red_count = COUNT_FIELD_BITS'(count_rd[0]);
                    result_next.green_count = is_color_reg ? COUNT_FIELD_BITS'(count_rd[1])
                                                           : COUNT_FIELD_BITS'(count_rd[0]);
                    result_next.blue_count  = is_color_reg ? COUNT_FIELD_BITS'(count_rd[2])
                                                           : COUNT_FIELD_BITS'(count_rd[0]);
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_CLEAR;
            clr_addr_reg     <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            clr_addr_reg     <= clr_addr_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // A result only appears after the memory read of a read transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_REPLY))
        else $error("Result raised without a preceding bin read.");

    // An accepted accumulate transaction moves on to the scaling step.
    assert property (@(posedge clk) disable iff (!rst_n)
        (pixel_accept && (pixel.action == ACT_ACCUMULATE)) |=> (state_reg == S_SCALE))
        else $error("Accumulate transaction did not enter the scaling step.");

    // The bin memories are never read and written in the same cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        !(mem_wr_en && mem_rd_en))
        else $error("Bin memory read and write collided.");

    // A write-back always follows the read issued for it.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_UPDATE) |-> $past(mem_rd_en))
        else $error("Bin update without a preceding read.");

endmodule

/* dv/histogram_checker.sv */
// Bin count checker for the RGB pixel histogram: follows the register port and both
// transaction channels, keeps its own bin stores and compares every read result.
// Depends on rph_pkg.
module histogram_checker
    import rph_pkg::*;
#(
    parameter int BIN_BITS   = DEFAULT_BIN_BITS,
    parameter int COUNT_BITS = DEFAULT_COUNT_BITS
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_wdata,
    input  logic                      pixel_valid,
    input  logic                      pixel_ready,
    input  pixel_t                    pixel,
    input  logic                      result_valid,
    input  logic                      result_ready,
    input  result_t                   result,
    output int                        failures,
    output int                        outstanding,
    output int                        reads_checked,
    output int                        pixels_seen
);

    localparam int RED   = 0;
    localparam int GREEN = 1;
    localparam int BLUE  = 2;
    localparam int MAX_REPORTS = 10;

    localparam logic [BIN_BITS-1:0]   LAST_BIN   = '1;
    localparam logic [COUNT_BITS-1:0] FULL_COUNT = '1;

    logic [COUNT_BITS-1:0] tally [int unsigned];
    result_t               due_counts [$];
    logic [GAIN_BITS-1:0]  gain_now = GAIN_RESET;
    logic                  colour_now = 1'b1;

    result_t               want;
    result_t               got;
    logic [BIN_BITS-1:0]   read_bin;
    logic [COUNT_BITS-1:0] red_now;

    initial
    begin
        failures      = 0;
        outstanding   = 0;
        reads_checked = 0;
        pixels_seen   = 0;
    end

    function automatic int unsigned slot(input int channel, input logic [BIN_BITS-1:0] bin);
        return (channel << BIN_BITS) | int'(bin);
    endfunction

    function automatic logic [COUNT_BITS-1:0] count_of(input int channel,
                                                       input logic [BIN_BITS-1:0] bin);
        int unsigned key;
        key = slot(channel, bin);
        return tally.exists(key) ? tally[key] : '0;
    endfunction

    function automatic logic [BIN_BITS-1:0] scaled_bin(input logic [SAMPLE_BITS-1:0] sample);
        logic [PRODUCT_BITS-1:0] product;
        logic [SCALED_BITS-1:0]  scaled;
        product = PRODUCT_BITS'(sample) * PRODUCT_BITS'(gain_now);
        scaled  = product[PRODUCT_BITS-1:BIN_SHIFT];
        if (scaled > SCALED_BITS'(LAST_BIN))
        begin
            scaled = SCALED_BITS'(LAST_BIN);
        end
        return scaled[BIN_BITS-1:0];
    endfunction

    task automatic bump(input int channel, input logic [SAMPLE_BITS-1:0] sample);
        logic [BIN_BITS-1:0]   bin;
        logic [COUNT_BITS-1:0] count;
        bin   = scaled_bin(sample);
        count = count_of(channel, bin);
        if (count != FULL_COUNT)
        begin
            tally[slot(channel, bin)] = count + 1'b1;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tally.delete();
            due_counts.delete();
            gain_now   = GAIN_RESET;
            colour_now = 1'b1;
        end
        else
        begin
            if (result_valid && result_ready)
            begin
                got = result;
                if (due_counts.size() == 0)
                begin
                    failures++;
                    if (failures <= MAX_REPORTS)
                    begin
                        $display("Unexpected result transaction: red %0d green %0d blue %0d",
                                 got.red_count, got.green_count, got.blue_count);
                    end
                end
                else
                begin
                    want = due_counts.pop_front();
                    reads_checked++;
                    if (got.red_count !== want.red_count
                        || got.green_count !== want.green_count
                        || got.blue_count !== want.blue_count)
                    begin
                        failures++;
                        if (failures <= MAX_REPORTS)
                        begin
                            $display("Count mismatch: expected %0d/%0d/%0d, got %0d/%0d/%0d",
                                     want.red_count, want.green_count, want.blue_count,
                                     got.red_count, got.green_count, got.blue_count);
                        end
                    end
                end
            end

            if (pixel_valid && pixel_ready)
            begin
                pixels_seen++;
                if (pixel.action == ACT_ACCUMULATE)
                begin
                    bump(RED, pixel.red_sample);
                    bump(GREEN, pixel.green_sample);
                    bump(BLUE, pixel.blue_sample);
                end
                else
                begin
                    read_bin = pixel.bin_index[BIN_BITS-1:0];
                    red_now  = count_of(RED, read_bin);
                    want.red_count   = COUNT_FIELD_BITS'(red_now);
                    want.green_count = COUNT_FIELD_BITS'(colour_now
                                                         ? count_of(GREEN, read_bin) : red_now);
                    want.blue_count  = COUNT_FIELD_BITS'(colour_now
                                                         ? count_of(BLUE, read_bin) : red_now);
                    due_counts.push_back(want);
                end
            end

            if (cfg_wr_en)
            begin
                if (cfg_index == REG_GAIN)
                begin
                    gain_now = cfg_wdata[GAIN_BITS-1:0];
                end
                else if (cfg_index == REG_IS_COLOR)
                begin
                    colour_now = cfg_wdata[0];
                end
            end
        end
        outstanding = due_counts.size();
    end

endmodule

/* dv/testbench.sv */
// Top of the RGB pixel histogram testbench: clock, reset, register writes and pixel
// transactions, with the bin count checker beside the block. Depends on rph_pkg,
// rgb_pixel_histogram and histogram_checker.
module testbench;

    import rph_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int SETTLE_CYCLES = 8;
    localparam int IDLE_PERCENT  = 13;
    localparam int RECENT_DEPTH  = 16;

    logic                      clk = 1'b0;
    logic                      rst_n = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = REG_GAIN;
    logic [CFG_DATA_BITS-1:0]  cfg_wdata = '0;
    logic                      pixel_valid = 1'b0;
    logic                      pixel_ready;
    pixel_t                    pixel = '0;
    logic                      result_valid;
    logic                      result_ready = 1'b0;
    result_t                   result;

    int failures;
    int outstanding;
    int reads_checked;
    int pixels_seen;
    int cycles = 0;
    int settings_used = 0;
    bit steady = 1'b0;

    logic [GAIN_BITS-1:0]   gain_now = GAIN_RESET;
    logic [SAMPLE_BITS-1:0] recent_samples [$];

    rgb_pixel_histogram dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_wdata    (cfg_wdata),
        .pixel_valid  (pixel_valid),
        .pixel_ready  (pixel_ready),
        .pixel        (pixel),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result)
    );

    histogram_checker tally_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .pixel_valid   (pixel_valid),
        .pixel_ready   (pixel_ready),
        .pixel         (pixel),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .result        (result),
        .failures      (failures),
        .outstanding   (outstanding),
        .reads_checked (reads_checked),
        .pixels_seen   (pixels_seen)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles++;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("Run stopped after %0d cycles with %0d results outstanding.",
                     cycles, outstanding);
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(negedge clk)
    begin
        result_ready = steady || ($urandom_range(0, 99) >= IDLE_PERCENT);
    end

    function automatic logic [INDEX_FIELD_BITS-1:0] target_bin(input logic [SAMPLE_BITS-1:0] s);
        logic [PRODUCT_BITS-1:0] product;
        product = PRODUCT_BITS'(s) * PRODUCT_BITS'(gain_now);
        product = product >> BIN_SHIFT;
        if (product > PRODUCT_BITS'({INDEX_FIELD_BITS{1'b1}}))
        begin
            return '1;
        end
        return product[INDEX_FIELD_BITS-1:0];
    endfunction

    function automatic logic [SAMPLE_BITS-1:0] pick_sample();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 40)
        begin
            return SAMPLE_BITS'($urandom_range(0, 16'h0FFF));
        end
        else if (roll < 55)
        begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        return SAMPLE_BITS'($urandom);
    endfunction

    function automatic logic [INDEX_FIELD_BITS-1:0] pick_read_bin();
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 50 && recent_samples.size() > 0)
        begin
            return target_bin(recent_samples[$urandom_range(0, recent_samples.size() - 1)]);
        end
        else if (roll < 65)
        begin
            return $urandom_range(0, 1) ? '1 : '0;
        end
        else if (roll < 80)
        begin
            return INDEX_FIELD_BITS'($urandom_range(0, 255));
        end
        return INDEX_FIELD_BITS'($urandom);
    endfunction

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] index,
                             input logic [CFG_DATA_BITS-1:0] data);
        cfg_index = index;
        cfg_wdata = data;
        cfg_wr_en = 1'b1;
        @(negedge clk);
        cfg_wr_en = 1'b0;
        if (index == REG_GAIN)
        begin
            gain_now = data[GAIN_BITS-1:0];
        end
    endtask

    task automatic send_pixel(input pixel_t item);
        while (!steady && $urandom_range(0, 99) < IDLE_PERCENT)
        begin
            pixel_valid = 1'b0;
            @(negedge clk);
        end
        pixel       = item;
        pixel_valid = 1'b1;
        @(posedge clk);
        while (!pixel_ready)
        begin
            @(posedge clk);
        end
        @(negedge clk);
        if (item.action == ACT_ACCUMULATE)
        begin
            recent_samples.push_back(item.red_sample);
            recent_samples.push_back(item.green_sample);
            recent_samples.push_back(item.blue_sample);
            while (recent_samples.size() > RECENT_DEPTH)
            begin
                void'(recent_samples.pop_front());
            end
        end
    endtask

    task automatic accumulate(input logic [SAMPLE_BITS-1:0] red_s,
                              input logic [SAMPLE_BITS-1:0] green_s,
                              input logic [SAMPLE_BITS-1:0] blue_s);
        pixel_t item;
        item.action       = ACT_ACCUMULATE;
        item.red_sample   = red_s;
        item.green_sample = green_s;
        item.blue_sample  = blue_s;
        item.bin_index    = INDEX_FIELD_BITS'($urandom);
        send_pixel(item);
    endtask

    task automatic read_counts(input logic [INDEX_FIELD_BITS-1:0] bin);
        pixel_t item;
        item.action       = ACT_READ;
        item.red_sample   = SAMPLE_BITS'($urandom);
        item.green_sample = SAMPLE_BITS'($urandom);
        item.blue_sample  = SAMPLE_BITS'($urandom);
        item.bin_index    = bin;
        send_pixel(item);
    endtask

    task automatic settle();
        pixel_valid = 1'b0;
        while (outstanding != 0)
        begin
            @(negedge clk);
        end
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic run_phase(input logic [GAIN_BITS-1:0] gain, input logic colour,
                             input int items, input bit calm);
        write_reg(REG_GAIN, CFG_DATA_BITS'(gain));
        write_reg(REG_IS_COLOR, CFG_DATA_BITS'(colour));
        settings_used++;
        steady = calm;
        repeat (items)
        begin
            if ($urandom_range(0, 99) < 70)
            begin
                accumulate(pick_sample(), pick_sample(), pick_sample());
            end
            else
            begin
                read_counts(pick_read_bin());
            end
        end
        settle();
        steady = 1'b0;
    endtask

    initial
    begin
        repeat (9) @(negedge clk);
        rst_n = 1'b1;

        write_reg(REG_GAIN, CFG_DATA_BITS'(GAIN_RESET));
        write_reg(REG_IS_COLOR, CFG_DATA_BITS'(1));
        settings_used++;
        accumulate(16'h0000, 16'h0000, 16'h0000);
        accumulate(16'hFFFF, 16'h0100, 16'h8000);
        accumulate(16'hFFFF, 16'hFFFF, 16'hFFFF);
        read_counts(16'h0000);
        read_counts(16'h00FF);
        read_counts(16'h0001);
        read_counts(16'h0080);
        read_counts(16'hFFFF);
        read_counts(16'h8000);
        read_counts(16'h5AA5);
        settle();

        write_reg(REG_GAIN, '1);
        settings_used++;
        accumulate(16'hFFFF, 16'h0001, 16'h0000);
        read_counts(16'hFFFF);
        read_counts(16'h00FF);
        read_counts(16'h0000);
        settle();

        write_reg(REG_IS_COLOR, CFG_DATA_BITS'(0));
        settings_used++;
        read_counts(16'h0000);
        read_counts(16'h00FF);
        read_counts(16'hFFFF);
        read_counts(16'h0080);
        settle();

        write_reg(REG_GAIN, '0);
        settings_used++;
        accumulate(16'h1234, 16'hFFFF, 16'h8000);
        read_counts(16'h0000);
        settle();

        run_phase(32'h0100_0000, 1'b1, 120, 1'b0);
        run_phase(32'h0010_0000, 1'b0, 100, 1'b0);
        run_phase(32'hFFFF_FFFF, 1'b1, 80, 1'b0);
        run_phase(32'h0000_0000, 1'b0, 60, 1'b0);
        run_phase(32'h0100_0000, 1'b1, 120, 1'b1);
        run_phase(GAIN_BITS'($urandom), 1'($urandom), 120, 1'b0);

        $display("Checked %0d read results after %0d pixel transactions in total,",
                 reads_checked, pixels_seen);
        $display("over %0d gain and colour settings, zero and full-scale gain included.",
                 settings_used);
        if (failures == 0 && outstanding == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("%0d mismatches, %0d results never arrived.", failures, outstanding);
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

/* sim.f */
src/rph_pkg.sv
src/rph_scale.sv
src/rph_bank.sv
src/rgb_pixel_histogram.sv
dv/histogram_checker.sv
dv/testbench.sv
